FILE: rtl/slu_pkg.sv
// Package for the serial line unit register block.
// Holds the request and response transfer types, the state record and the codes.
// No dependencies.
package slu_pkg;

  typedef enum logic [2:0] {
    REQ_READ    = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_RX_BYTE = 3'd2,
    REQ_TX_DONE = 3'd3,
    REQ_INIT    = 3'd4
  } slu_req_e;

  typedef enum logic [1:0] {
    SEL_RX_STATUS = 2'd0,
    SEL_RX_BUFFER = 2'd1,
    SEL_TX_STATUS = 2'd2,
    SEL_TX_BUFFER = 2'd3
  } slu_reg_e;

  // Bit positions in the control and status words.
  localparam int unsigned CSR_ACTIVE_BIT  = 11;
  localparam int unsigned CSR_DONE_BIT    = 7;
  localparam int unsigned CSR_IE_BIT      = 6;
  localparam int unsigned CSR_MAINT_BIT   = 2;
  localparam int unsigned CSR_ENABLE_BIT  = 0;
  localparam int unsigned BUF_ERR_BIT     = 15;
  localparam int unsigned BUF_OVERRUN_BIT = 14;
  localparam int unsigned BUF_FRAMING_BIT = 13;
  localparam int unsigned BUF_PARITY_BIT  = 12;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  reg_index;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;
    logic        rx_line_error;
  } slu_req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        rx_irq;
    logic        tx_irq;
    logic        tx_start;
    logic [7:0]  tx_byte;
    logic        break_level;
  } slu_rsp_t;

  typedef struct packed {
    logic       rx_active;
    logic       rx_done;
    logic       rx_int_enable;
    logic       reader_enable;
    logic       overrun_flag;
    logic       framing_flag;
    logic       parity_flag;
    logic [7:0] rx_char;
    logic       tx_ready;
    logic       tx_int_enable;
    logic       maint_loop;
    logic       break_on;
    logic [7:0] tx_char;
  } slu_state_t;

  localparam slu_state_t SLU_STATE_RESET = '{
    rx_active:     1'b0,
    rx_done:       1'b0,
    rx_int_enable: 1'b0,
    reader_enable: 1'b0,
    overrun_flag:  1'b0,
    framing_flag:  1'b0,
    parity_flag:   1'b0,
    rx_char:       8'h00,
    tx_ready:      1'b1,
    tx_int_enable: 1'b0,
    maint_loop:    1'b0,
    break_on:      1'b0,
    tx_char:       8'h00
  };

endpackage

FILE: rtl/slu_read_mux.sv
// Read data composer for the serial line unit registers.
// Depends on slu_pkg for the state record and register codes.
module slu_read_mux
  import slu_pkg::*;
(
  input  slu_state_t  state_i,
  input  logic [1:0]  reg_index_i,
  output logic [15:0] read_data_o
);

  logic any_err;

  assign any_err = state_i.overrun_flag | state_i.framing_flag | state_i.parity_flag;

  always_comb begin
    read_data_o = '0;
    case (reg_index_i)
      SEL_RX_STATUS: begin
        read_data_o[CSR_ACTIVE_BIT] = state_i.rx_active;
        read_data_o[CSR_DONE_BIT]   = state_i.rx_done;
        read_data_o[CSR_IE_BIT]     = state_i.rx_int_enable;
      end
      SEL_RX_BUFFER: begin
        read_data_o[BUF_ERR_BIT]     = any_err;
        read_data_o[BUF_OVERRUN_BIT] = state_i.overrun_flag;
        read_data_o[BUF_FRAMING_BIT] = state_i.framing_flag;
        read_data_o[BUF_PARITY_BIT]  = state_i.parity_flag;
        read_data_o[7:0]             = state_i.rx_char;
      end
      SEL_TX_STATUS: begin
        read_data_o[CSR_DONE_BIT]   = state_i.tx_ready;
        read_data_o[CSR_IE_BIT]     = state_i.tx_int_enable;
        read_data_o[CSR_MAINT_BIT]  = state_i.maint_loop;
        read_data_o[CSR_ENABLE_BIT] = state_i.break_on;
      end
      default: begin
        read_data_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/slu_core.sv
// Register state and update logic of the serial line unit.
// Depends on slu_pkg and instantiates slu_read_mux.
module slu_core
  import slu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  slu_req_t req_i,
  output slu_rsp_t rsp_o
);

  slu_state_t  state_q, state_d;
  logic [15:0] rd_data;

  slu_read_mux u_read_mux (
    .state_i     (state_q),
    .reg_index_i (req_i.reg_index),
    .read_data_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    rsp_o   = '0;
    case (req_i.req_type)
      REQ_READ: begin
        rsp_o.read_data = rd_data;
        if (req_i.reg_index == SEL_RX_BUFFER) begin
          state_d.rx_done = 1'b0;
        end
      end
      REQ_WRITE: begin
        case (req_i.reg_index)
          SEL_RX_STATUS: begin
            state_d.rx_int_enable = req_i.write_data[CSR_IE_BIT];
            state_d.reader_enable = req_i.write_data[CSR_ENABLE_BIT];
            // Turning the reader on discards a pending character.
            if (!state_q.reader_enable && req_i.write_data[CSR_ENABLE_BIT]) begin
              state_d.rx_done = 1'b0;
            end
            rsp_o.rx_irq = !(state_q.rx_done && state_q.rx_int_enable) &&
                           state_d.rx_done && state_d.rx_int_enable;
          end
          SEL_RX_BUFFER: begin
            state_d.rx_done = 1'b0;
          end
          SEL_TX_STATUS: begin
            state_d.tx_int_enable = req_i.write_data[CSR_IE_BIT];
            state_d.maint_loop    = req_i.write_data[CSR_MAINT_BIT];
            state_d.break_on      = req_i.write_data[CSR_ENABLE_BIT];
            rsp_o.tx_irq = !(state_q.tx_ready && state_q.tx_int_enable) &&
                           state_q.tx_ready && req_i.write_data[CSR_IE_BIT];
          end
          default: begin
            state_d.tx_char  = req_i.write_data[7:0];
            state_d.tx_ready = 1'b0;
            rsp_o.tx_start   = 1'b1;
            rsp_o.tx_byte    = req_i.write_data[7:0];
            if (state_q.maint_loop) begin
              state_d.rx_active = 1'b1;
            end
          end
        endcase
      end
      REQ_RX_BYTE: begin
        state_d.overrun_flag = state_q.rx_done;
        state_d.framing_flag = req_i.rx_line_error;
        state_d.parity_flag  = req_i.rx_line_error;
        state_d.rx_char      = req_i.rx_byte;
        state_d.rx_done      = 1'b1;
        state_d.rx_active    = 1'b0;
        rsp_o.rx_irq = !(state_q.rx_done && state_q.rx_int_enable) && state_q.rx_int_enable;
      end
      REQ_TX_DONE: begin
        if (!state_q.tx_ready) begin
          state_d.tx_ready = 1'b1;
          rsp_o.tx_irq     = state_q.tx_int_enable;
          if (state_q.maint_loop) begin
            // Loopback: the transmitted character arrives as a byte free of framing and parity errors.
            state_d.overrun_flag = state_q.rx_done;
            state_d.framing_flag = 1'b0;
            state_d.parity_flag  = 1'b0;
            state_d.rx_char      = state_q.tx_char;
            state_d.rx_done      = 1'b1;
            state_d.rx_active    = 1'b0;
            rsp_o.rx_irq = !(state_q.rx_done && state_q.rx_int_enable) &&
                           state_q.rx_int_enable;
          end else begin
            state_d.rx_active = 1'b0;
          end
        end
      end
      REQ_INIT: begin
        state_d = SLU_STATE_RESET;
      end
      default: begin
        state_d = state_q;
      end
    endcase
    rsp_o.break_level = state_d.break_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLU_STATE_RESET;
    end else if (valid_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/serial_line_unit_registers.sv
// Serial line unit register block: a transfer accepted on start_i passes the input and
// result registers to its result strobe on result_valid_o; one transfer is taken every cycle.
// The block never raises busy_o, and results cannot be stalled by the receiver.
// Asynchronous active-low reset returns every register flag to its power-up value
// (transmitter ready, all else clear) and drops the input and result strobes.
// Depends on slu_pkg; instantiates slu_core.
module serial_line_unit_registers
  import slu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  slu_req_t req_i,
  output logic     busy_o,
  output logic     result_valid_o,
  output slu_rsp_t rsp_o
);

  // Every request is a single flag update plus a read multiplexer, so the input
  // register feeds the core directly and the result register follows it. The core
  // state changes at the same edge that captures the result, so a request waiting
  // in the input register always sees the effect of the one ahead of it.
  logic     in_valid_q;
  slu_req_t in_q;
  slu_rsp_t rsp_d, rsp_q;
  logic     result_valid_q;
  logic     accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register: one transfer per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // The payload needs no reset; it is qualified by in_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i;
    end
  end

  slu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .req_i   (in_q),
    .rsp_o   (rsp_d)
  );

  // Result register: each result is shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

endmodule

FILE: rtl/slu_checker.sv
// Port-level checker for the serial line unit register block, with its bind.
// Depends on slu_pkg; attaches to serial_line_unit_registers.
module slu_checker
  import slu_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     result_valid_o,
  input slu_rsp_t rsp_o
);

  // Every accepted transfer produces a result after the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("accepted transfer gave no result");

  // No result appears without an accepted transfer ahead of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted transfer");

  // The transmit byte is zero unless a transmission starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !rsp_o.tx_start) |-> (rsp_o.tx_byte == 8'h00))
    else $error("tx_byte set without tx_start");

  // A buffer write starts a transmission and raises no interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.tx_start) |-> (!rsp_o.tx_irq && !rsp_o.rx_irq &&
                                            rsp_o.read_data == 16'h0000))
    else $error("transmit start combined with interrupt or read data");

endmodule

bind serial_line_unit_registers slu_checker u_slu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);
